[design/ams_pkg.sv]
// Shared types, register indexes and character helpers for the anchored substring matcher.
package ams_pkg;

   localparam int CHAR_W      = 8;
   localparam int PAT_BYTES   = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PLEN_W      = 6;

   typedef logic [CHAR_W-1:0]                   char_type;
   typedef logic [PAT_BYTES-1:0][CHAR_W-1:0]    pat_type;
   typedef logic [CSR_IDX_W-1:0]                csr_idx_type;

   // config register indexes
   localparam csr_idx_type REG_PAT_A  = 3'd0;
   localparam csr_idx_type REG_PAT_B  = 3'd1;
   localparam csr_idx_type REG_PAT_C  = 3'd2;
   localparam csr_idx_type REG_PAT_D  = 3'd3;
   localparam csr_idx_type REG_PLEN   = 3'd4;
   localparam csr_idx_type REG_ANC_B  = 3'd5;
   localparam csr_idx_type REG_ANC_E  = 3'd6;
   localparam csr_idx_type REG_NEGATE = 3'd7;

   // compare control broadcast to every window cell
   typedef struct packed {
      logic              icase;
      logic [PLEN_W-1:0] act_len;
   } cmp_ctrl_type;

   function automatic char_type fold_upper(input char_type c);
      char_type r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

   function automatic logic is_upper(input char_type c);
      return (c >= 8'h41 && c <= 8'h5a);
   endfunction

   function automatic logic same_char(input char_type a, input char_type b, input logic icase);
      logic r;
      if (icase) begin
         r = (fold_upper(a) == fold_upper(b));
      end else begin
         r = (a == b);
      end
      return r;
   endfunction

   // pattern bytes past the stored 32 read as zero
   function automatic char_type pattern_byte(input pat_type pat, input logic [PLEN_W-1:0] idx);
      char_type r;
      if (idx[PLEN_W-1]) begin
         r = '0;
      end else begin
         r = pat[idx[PLEN_W-2:0]];
      end
      return r;
   endfunction

endpackage

[design/anchored_substring_matcher.sv]
// Top level: config registers, name tracking, the window cell chain and the result register.
//
//   channel   ports                                   dir   notes
//   req       req_valid/ready, char_code, last_char  in    one name byte per word
//   rsp       rsp_valid/ready, matched               out   one word per name, on last byte
//   csr       csr_wr_en, csr_index, csr_wdata        in    write only, no wait
//
// One word is taken every cycle unless a stalled result holds input off; the whole
// decision for a byte is made by the parallel compares of the window cells and the
// prefix check in the cycle it is accepted. The result shows in the cycle after the
// last byte and sits in the output register; a stalled result blocks input only while it is not taken.
// Synchronous reset clears config, name state and the result valid flag, not the match bit.
module anchored_substring_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ams_pkg::CHAR_W-1:0]         req_char_code,
   input  logic                               req_last_char,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_matched,
   input  logic                               csr_wr_en,
   input  logic [ams_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ams_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 2);
   localparam int CMP_W = (LEN_W > ams_pkg::PLEN_W) ? LEN_W : ams_pkg::PLEN_W;
   localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_PATTERN + 1);

   // config
   ams_pkg::pat_type               pat_ff;
   logic [ams_pkg::PLEN_W-1:0]     plen_ff;
   logic                           anc_b_ff;
   logic                           anc_e_ff;
   logic                           negate_ff;

   // name state
   logic [LEN_W-1:0]               nlen_ff;
   logic [LEN_W-1:0]               nlen_in;
   logic                           prefix_ff;
   logic                           prefix_in;
   logic                           found_ff;
   logic                           found_in;

   logic                           rsp_valid_ff;
   logic                           matched_ff;
   logic                           matched_in;

   logic                           accept;
   ams_pkg::cmp_ctrl_type          ctrl;
   logic                           has_upper;
   logic                           hit;
   logic [CMP_W-1:0]               nlen_cmp;
   logic [CMP_W-1:0]               n_cmp;

   ams_pkg::char_type              win [MAX_PATTERN];
   logic [MAX_PATTERN-1:0]         cell_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff    <= '0;
         plen_ff   <= '0;
         anc_b_ff  <= 1'b0;
         anc_e_ff  <= 1'b0;
         negate_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ams_pkg::REG_PAT_A:  pat_ff[7:0]   <= csr_wdata;
            ams_pkg::REG_PAT_B:  pat_ff[15:8]  <= csr_wdata;
            ams_pkg::REG_PAT_C:  pat_ff[23:16] <= csr_wdata;
            ams_pkg::REG_PAT_D:  pat_ff[31:24] <= csr_wdata;
            ams_pkg::REG_PLEN:   plen_ff   <= csr_wdata[ams_pkg::PLEN_W-1:0];
            ams_pkg::REG_ANC_B:  anc_b_ff  <= csr_wdata[0];
            ams_pkg::REG_ANC_E:  anc_e_ff  <= csr_wdata[0];
            ams_pkg::REG_NEGATE: negate_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // active length clamps to the window depth; smart case over active bytes
   always_comb begin
      if ({1'b0, plen_ff} > (ams_pkg::PLEN_W + 1)'(MAX_PATTERN)) begin
         ctrl.act_len = ams_pkg::PLEN_W'(MAX_PATTERN);
      end else begin
         ctrl.act_len = plen_ff;
      end
      has_upper = 1'b0;
      for (int i = 0; i < ams_pkg::PAT_BYTES; i++) begin
         if ((ams_pkg::PLEN_W'(i) < ctrl.act_len) && ams_pkg::is_upper(pat_ff[i])) begin
            has_upper = 1'b1;
         end
      end
      ctrl.icase = ~has_upper;
   end

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      ams_pkg::char_type cell_in;
      if (j == 0) begin : g_head
         assign cell_in = req_char_code;
      end else begin : g_body
         assign cell_in = win[j-1];
      end
      ams_cell #(
         .IDX (j)
      ) u_cell (
         .clock    (clock),
         .shift_en (accept),
         .byte_in  (cell_in),
         .pattern  (pat_ff),
         .ctrl     (ctrl),
         .byte_out (win[j]),
         .cmp_ok   (cell_ok[j])
      );
   end

   always_comb begin
      prefix_in = prefix_ff;
      if ((CMP_W'(nlen_ff) < CMP_W'(ctrl.act_len)) &&
          !ams_pkg::same_char(req_char_code,
                              ams_pkg::pattern_byte(pat_ff, ams_pkg::PLEN_W'(nlen_ff)),
                              ctrl.icase)) begin
         prefix_in = 1'b0;
      end
      if (nlen_ff < LEN_SAT) begin
         nlen_in = nlen_ff + 1'b1;
      end else begin
         nlen_in = nlen_ff;
      end
      nlen_cmp = CMP_W'(nlen_in);
      n_cmp    = CMP_W'(ctrl.act_len);
      hit      = (&cell_ok) && (ctrl.act_len != '0) && (nlen_cmp >= n_cmp);
      found_in = found_ff | hit;

      priority if (ctrl.act_len == '0) begin
         matched_in = 1'b1;
      end else if (nlen_cmp < n_cmp) begin
         matched_in = 1'b0;
      end else if (anc_b_ff && anc_e_ff) begin
         matched_in = (nlen_cmp == n_cmp) && prefix_in;
      end else if (anc_b_ff) begin
         matched_in = prefix_in;
      end else if (anc_e_ff) begin
         matched_in = hit;
      end else begin
         matched_in = found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nlen_ff   <= '0;
         prefix_ff <= 1'b1;
         found_ff  <= 1'b0;
      end else if (accept) begin
         if (req_last_char) begin
            nlen_ff   <= '0;
            prefix_ff <= 1'b1;
            found_ff  <= 1'b0;
         end else begin
            nlen_ff   <= nlen_in;
            prefix_ff <= prefix_in;
            found_ff  <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && req_last_char) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_char) begin
         matched_ff <= matched_in ^ negate_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = matched_ff;

endmodule

[design/ams_cell.sv]
// One window cell: holds a name byte, passes it on, and checks its incoming byte against the pattern.
module ams_cell #(
   parameter int IDX = 0
) (
   input  logic                  clock,
   input  logic                  shift_en,
   input  ams_pkg::char_type     byte_in,
   input  ams_pkg::pat_type      pattern,
   input  ams_pkg::cmp_ctrl_type ctrl,
   output ams_pkg::char_type     byte_out,
   output logic                  cmp_ok
);

   localparam logic [ams_pkg::PLEN_W-1:0] CELL_IDX = ams_pkg::PLEN_W'(IDX);

   ams_pkg::char_type            byte_ff;
   logic [ams_pkg::PLEN_W-1:0]   pat_idx;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

   // cell j lines up with pattern byte (len-1-j) once the new byte lands
   always_comb begin
      pat_idx = ctrl.act_len - CELL_IDX - 1'b1;
      if (CELL_IDX >= ctrl.act_len) begin
         cmp_ok = 1'b1;
      end else begin
         cmp_ok = ams_pkg::same_char(byte_in, ams_pkg::pattern_byte(pattern, pat_idx),
                                     ctrl.icase);
      end
   end

endmodule

[tb/anchored_substring_matcher_chk.sv]
// Checker for the anchored substring matcher: mirrors config and name state, predicts match words.
module anchored_substring_matcher_chk (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [ams_pkg::CHAR_W-1:0]      req_char_code,
   input  logic                            req_last_char,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_matched,
   input  logic                            csr_wr_en,
   input  logic [ams_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ams_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              error_count,
   output int                              match_backlog
);

   localparam int WIN_DEPTH = 32;
   localparam int SAT_LEN   = WIN_DEPTH + 1;

   // mirrored config
   logic [63:0]       pat_word [4];
   logic [5:0]        pat_len_reg;
   logic              anchor_head;
   logic              anchor_tail;
   logic              invert;

   // mirrored name state
   ams_pkg::char_type recent [WIN_DEPTH];
   int                seen_len;
   logic              head_ok;
   logic              seen_anywhere;

   logic              match_q [$];
   logic              want;
   int                fails = 0;
   int                backlog = 0;

   assign error_count   = fails;
   assign match_backlog = backlog;

   task automatic report(input string what);
      fails++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic ams_pkg::char_type pat_char(input int i);
      if (i >= WIN_DEPTH) begin
         return 8'h00;
      end
      return pat_word[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic ams_pkg::char_type to_upper(input ams_pkg::char_type c);
      if (c >= "a" && c <= "z") begin
         return c - 8'd32;
      end
      return c;
   endfunction

   function automatic logic chars_equal(input ams_pkg::char_type a, input ams_pkg::char_type b,
                                        input logic fold);
      if (fold) begin
         return to_upper(a) == to_upper(b);
      end
      return a == b;
   endfunction

   task automatic clear_name();
      int k;
      for (k = 0; k < WIN_DEPTH; k++) begin
         recent[k] = 8'h00;
      end
      seen_len      = 0;
      head_ok       = 1'b1;
      seen_anywhere = 1'b0;
   endtask

   // one name byte; on the closing byte the match word is queued
   task automatic take_char(input ams_pkg::char_type c, input logic last);
      int   span;
      int   k;
      logic fold;
      logic hit;
      logic m;
      span = (pat_len_reg > WIN_DEPTH) ? WIN_DEPTH : int'(pat_len_reg);
      // case is ignored unless the active pattern holds an uppercase letter
      fold = 1'b1;
      for (k = 0; k < span; k++) begin
         if (pat_char(k) >= "A" && pat_char(k) <= "Z") begin
            fold = 1'b0;
         end
      end
      if (seen_len < span && !chars_equal(c, pat_char(seen_len), fold)) begin
         head_ok = 1'b0;
      end
      for (k = WIN_DEPTH - 1; k > 0; k--) begin
         recent[k] = recent[k-1];
      end
      recent[0] = c;
      if (seen_len < SAT_LEN) begin
         seen_len++;
      end
      hit = (span != 0) && (seen_len >= span);
      for (k = 0; k < span; k++) begin
         if (!chars_equal(recent[span-1-k], pat_char(k), fold)) begin
            hit = 1'b0;
         end
      end
      if (hit) begin
         seen_anywhere = 1'b1;
      end
      if (last) begin
         if (span == 0) begin
            m = 1'b1;
         end else if (seen_len < span) begin
            m = 1'b0;
         end else if (anchor_head && anchor_tail) begin
            m = (seen_len == span) && head_ok;
         end else if (anchor_head) begin
            m = head_ok;
         end else if (anchor_tail) begin
            m = hit;
         end else begin
            m = seen_anywhere;
         end
         match_q = {match_q, m ^ invert};
         clear_name();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pat_word[0] = '0;
         pat_word[1] = '0;
         pat_word[2] = '0;
         pat_word[3] = '0;
         pat_len_reg = '0;
         anchor_head = 1'b0;
         anchor_tail = 1'b0;
         invert      = 1'b0;
         clear_name();
         match_q.delete();
      end else begin
         // result words show in the cycle after their last byte, so check before queueing
         if (rsp_valid && rsp_ready) begin
            if (match_q.size() == 0) begin
               report($sformatf("match word %0b with nothing expected", rsp_matched));
            end else begin
               want = match_q.pop_front();
               if (rsp_matched !== want) begin
                  report($sformatf("matched got %b want %b", rsp_matched, want));
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               ams_pkg::REG_PAT_A:  pat_word[0] = csr_wdata;
               ams_pkg::REG_PAT_B:  pat_word[1] = csr_wdata;
               ams_pkg::REG_PAT_C:  pat_word[2] = csr_wdata;
               ams_pkg::REG_PAT_D:  pat_word[3] = csr_wdata;
               ams_pkg::REG_PLEN:   pat_len_reg = csr_wdata[5:0];
               ams_pkg::REG_ANC_B:  anchor_head = csr_wdata[0];
               ams_pkg::REG_ANC_E:  anchor_tail = csr_wdata[0];
               ams_pkg::REG_NEGATE: invert      = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            take_char(req_char_code, req_last_char);
         end
      end
      backlog = match_q.size();
   end

endmodule

[tb/anchored_substring_matcher_tb.sv]
// Testbench top for the anchored substring matcher: clock, reset, name stimulus and verdict.
module anchored_substring_matcher_tb;

   localparam int RANDOM_WORDS   = 600;
   localparam int RESULT_LATENCY = 1;
   localparam int DRAIN_CYCLES   = 4;
   localparam int STALL_LIMIT    = 400;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   ams_pkg::char_type               req_char_code;
   logic                            req_last_char;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic                            rsp_matched;
   logic                            csr_wr_en;
   ams_pkg::csr_idx_type            csr_index;
   logic [ams_pkg::CSR_DATA_W-1:0]  csr_wdata;

   int                              fail_total;
   int                              backlog;

   // stimulus side config image
   ams_pkg::char_type               cfg_pat [32];
   logic [5:0]                      cfg_len;
   logic                            cfg_head;
   logic                            cfg_tail;
   logic                            cfg_neg;

   ams_pkg::char_type               name_buf [$];
   bit                              no_idle;
   int                              words_sent;

   anchored_substring_matcher uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_matched   (rsp_matched),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   anchored_substring_matcher_chk chk (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_matched   (rsp_matched),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (fail_total),
      .match_backlog (backlog)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #2 clock = ~clock;
      end
   end

   // leaves valid high on return; caller either sends again or drops it
   task automatic send_word(input ams_pkg::char_type c, input logic last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_name(input bit close);
      int i;
      for (i = 0; i < name_buf.size(); i++) begin
         send_word(name_buf[i], close && (i == name_buf.size() - 1));
      end
   endtask

   task automatic add_char(input ams_pkg::char_type c);
      name_buf = {name_buf, c};
   endtask

   task automatic send_text(input string s, input bit close);
      int i;
      name_buf.delete();
      for (i = 0; i < s.len(); i++) begin
         add_char(s[i]);
      end
      send_name(close);
   endtask

   // sender holds off until every match word is back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (backlog != 0) @(negedge clock);
      repeat (RESULT_LATENCY + 1) @(negedge clock);
   endtask

   task automatic csr_write(input ams_pkg::csr_idx_type idx, input logic [63:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   function automatic logic [63:0] pack_pat(input int w);
      logic [63:0] word;
      int          j;
      for (j = 0; j < 8; j++) begin
         word[j*8 +: 8] = cfg_pat[w*8 + j];
      end
      return word;
   endfunction

   task automatic load_cfg();
      settle();
      csr_write(ams_pkg::REG_PAT_A, pack_pat(0));
      csr_write(ams_pkg::REG_PAT_B, pack_pat(1));
      csr_write(ams_pkg::REG_PAT_C, pack_pat(2));
      csr_write(ams_pkg::REG_PAT_D, pack_pat(3));
      csr_write(ams_pkg::REG_PLEN, {58'd0, cfg_len});
      csr_write(ams_pkg::REG_ANC_B, {63'd0, cfg_head});
      csr_write(ams_pkg::REG_ANC_E, {63'd0, cfg_tail});
      csr_write(ams_pkg::REG_NEGATE, {63'd0, cfg_neg});
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_cfg(input string s, input logic [5:0] len, input logic head,
                          input logic tail, input logic neg);
      int i;
      for (i = 0; i < 32; i++) begin
         cfg_pat[i] = (i < s.len()) ? s[i] : 8'h00;
      end
      cfg_len  = len;
      cfg_head = head;
      cfg_tail = tail;
      cfg_neg  = neg;
   endtask

   // small alphabet so patterns actually show up in names, with some raw bytes mixed in
   function automatic ams_pkg::char_type pick_char(input bit allow_upper);
      ams_pkg::char_type c;
      case ($urandom_range(0, 15))
         0, 1:    c = "a";
         2, 3:    c = "b";
         4:       c = "c";
         5:       c = "A";
         6:       c = "B";
         7:       c = 8'h00;
         8:       c = 8'he1;
         9:       c = 8'hc1;
         default: c = 8'($urandom_range(0, 255));
      endcase
      if (!allow_upper && c >= "A" && c <= "Z") begin
         c = c | 8'h20;
      end
      return c;
   endfunction

   task automatic draw_cfg();
      int i;
      int pick;
      bit allow_upper;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         cfg_len = 6'd0;
      end else if (pick <= 2) begin
         cfg_len = 6'd32;
      end else if (pick == 3) begin
         cfg_len = 6'($urandom_range(33, 63));
      end else begin
         cfg_len = 6'($urandom_range(1, 5));
      end
      allow_upper = 1'($urandom_range(0, 1));
      for (i = 0; i < 32; i++) begin
         if (i < cfg_len) begin
            cfg_pat[i] = pick_char(allow_upper);
         end else begin
            cfg_pat[i] = 8'($urandom_range(0, 255));
         end
      end
      cfg_head = 1'($urandom_range(0, 1));
      cfg_tail = 1'($urandom_range(0, 1));
      cfg_neg  = 1'($urandom_range(0, 1));
   endtask

   // mostly the pattern embedded in filler, with case flips and the odd corrupted byte
   task automatic compose_name();
      int                span;
      int                lead;
      int                tail;
      int                len;
      int                i;
      ams_pkg::char_type c;
      name_buf.delete();
      span = (cfg_len > 32) ? 32 : int'(cfg_len);
      if (span > 0 && $urandom_range(0, 9) < 7) begin
         lead = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
         tail = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
         if ($urandom_range(0, 9) == 0) begin
            tail = $urandom_range(20, 34);
         end
         repeat (lead) add_char(pick_char(1'b1));
         for (i = 0; i < span; i++) begin
            c = cfg_pat[i];
            if ((c | 8'h20) >= "a" && (c | 8'h20) <= "z" && $urandom_range(0, 3) == 0) begin
               c = c ^ 8'h20;
            end
            if ($urandom_range(0, 15) == 0) begin
               c = pick_char(1'b1);
            end
            add_char(c);
         end
         repeat (tail) add_char(pick_char(1'b1));
      end else begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
         repeat (len) add_char(pick_char(1'b1));
      end
   endtask

   initial begin : stimulus
      int base;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_code = '0;
      req_last_char = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = ams_pkg::REG_PAT_A;
      csr_wdata     = '0;
      no_idle       = 1'b0;
      words_sent    = 0;
      for (int i = 0; i < 32; i++) begin
         cfg_pat[i] = 8'h00;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // config straight out of reset: empty pattern, zero byte name
      name_buf = '{8'h00};
      send_name(1'b1);

      set_cfg("", 6'd0, 1'b0, 1'b0, 1'b1);
      load_cfg();
      name_buf = '{8'hff};
      send_name(1'b1);

      // lowercase pattern folds case; one byte name is too short
      set_cfg("ab", 6'd2, 1'b0, 1'b0, 1'b0);
      load_cfg();
      send_text("xAB", 1'b1);
      send_text("a", 1'b1);

      // uppercase in the pattern makes it case exact
      set_cfg("aB", 6'd2, 1'b1, 1'b0, 1'b0);
      load_cfg();
      send_text("aBc", 1'b1);

      // zero and high bytes in the pattern, suffix mode; high bytes never fold
      set_cfg("", 6'd2, 1'b0, 1'b1, 1'b0);
      cfg_pat[1] = 8'he1;
      load_cfg();
      name_buf = '{8'h41, 8'h00, 8'hc1};
      send_name(1'b1);
      name_buf = '{8'h00, 8'he1};
      send_name(1'b1);

      set_cfg("Qz", 6'd2, 1'b1, 1'b1, 1'b0);
      load_cfg();
      send_text("Qz", 1'b1);

      // length past the window clamps to the full window
      set_cfg("", 6'd63, 1'b1, 1'b1, 1'b0);
      load_cfg();
      send_text("a", 1'b1);

      // pattern swapped in the middle of a name
      set_cfg("q", 6'd1, 1'b0, 1'b0, 1'b0);
      load_cfg();
      send_text("zz", 1'b0);
      set_cfg("z", 6'd1, 1'b1, 1'b0, 1'b1);
      load_cfg();
      send_text("y", 1'b1);

      base = words_sent;
      while (words_sent < base + RANDOM_WORDS) begin
         draw_cfg();
         load_cfg();
         no_idle = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(3, 8)) begin
            compose_name();
            send_name(1'b1);
         end
         // a name left open across the next config change now and then
         if ($urandom_range(0, 7) == 0) begin
            compose_name();
            send_name(1'b0);
         end
      end

      req_valid <= 1'b0;
      while (backlog != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_total == 0) begin
         $display("** anchored_substring_matcher: PASSED **");
      end else begin
         $display("** anchored_substring_matcher: FAILED **");
      end
      $finish;
   end

   // result side: stall is counted from when a word shows up
   initial begin : result_side
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (!rsp_valid);
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("** anchored_substring_matcher: FAILED **");
      $finish;
   end

endmodule
